### hdl/deq_pkg.sv
// Shared types and codes for the double-ended queue unit.
// Holds the request and response payload structs and the operation and status codes.
// Depends on nothing.
package deq_pkg;

	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_BACK   = 2'd3;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL = 2'd2;

	localparam int COUNT_OUT_W = 5;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] push_value;
	} deq_req_t;

	typedef struct packed {
		logic signed [31:0]     front_value;
		logic signed [31:0]     rear_value;
		logic                   is_empty;
		logic                   is_full;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [1:0]             status;
	} deq_rsp_t;

	typedef struct packed {
		logic       is_empty;
		logic       is_full;
		logic [1:0] status;
		logic       fwd_front;
		logic       fwd_rear;
	} deq_flags_t;

endpackage

### hdl/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit values held in a synchronous RAM.
// Request channel req (req_valid, req_ready) carries func and push_value; response
// channel rsp (rsp_valid, rsp_ready) carries one result per request transaction.
// A request transaction updates the head, tail and count registers, writes a pushed
// value and reads the new front and rear entries from the RAM at the same edge.
// The RAM read data is registered at that edge, and the result is then loaded into the output
// register once that register is free; a result passes the RAM read register and the output register.
// A new request is not taken before the result of the last one is loaded into the output register;
// req_ready is high again in the cycle after the result is loaded.
// A push on a full queue or a pop on an empty queue leaves the queue unchanged and
// reports status 2 or 1; an empty queue reports -1 as front and rear value.
// Reset (arst_n low) empties the queue and clears rsp_valid; the RAM is not cleared,
// and no entry that was not written reaches a response.
// While the receiver stalls, the result waits in the output register; the next request
// transaction is still taken, and its result waits in the RAM read register until the
// output register is free.
module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  deq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output deq_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic STATE_IDLE = 1'b0;
	localparam logic STATE_BUSY = 1'b1;

	logic               state_q;
	logic               accept, load_out;
	logic               wr_en;
	logic [AW-1:0]      wr_addr, rd_front_addr, rd_rear_addr;
	logic [CW-1:0]      count_next, count_s1;
	logic [CW+4:0]      count_ext;
	deq_flags_t         flags, flags_s1;
	logic signed [31:0] value_s1;
	logic [31:0]        rd_front, rd_rear;
	logic               out_valid_q;
	deq_rsp_t           out_q, out_n;

	assign req_ready = (state_q == STATE_IDLE);
	assign accept    = req_valid && req_ready;
	assign load_out  = (state_q == STATE_BUSY) && (!out_valid_q || rsp_ready);

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (req.func),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.rd_front_addr(rd_front_addr),
		.rd_rear_addr (rd_rear_addr),
		.count_next   (count_next),
		.flags        (flags)
	);

	deq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (wr_addr),
		.wdata  (req.push_value),
		.re     (accept),
		.raddr_a(rd_front_addr),
		.raddr_b(rd_rear_addr),
		.rdata_a(rd_front),
		.rdata_b(rd_rear)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
			count_s1 <= count_next;
			value_s1 <= req.push_value;
		end
		if (load_out) begin
			out_q <= out_n;
		end
	end

	assign count_ext = {5'd0, count_s1};

	always_comb begin
		out_n.is_empty    = flags_s1.is_empty;
		out_n.is_full     = flags_s1.is_full;
		out_n.status      = flags_s1.status;
		out_n.entry_count = count_ext[COUNT_OUT_W-1:0];
		if (flags_s1.is_empty) begin
			out_n.front_value = -32'sd1;
			out_n.rear_value  = -32'sd1;
		end else begin
			out_n.front_value = flags_s1.fwd_front ? value_s1 : $signed(rd_front);
			out_n.rear_value  = flags_s1.fwd_rear ? value_s1 : $signed(rd_rear);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				STATE_IDLE: begin
					if (accept) begin
						state_q <= STATE_BUSY;
					end
				end
				STATE_BUSY: begin
					if (load_out) begin
						state_q <= STATE_IDLE;
					end
				end
				default: begin
					state_q <= STATE_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef ASSERT_OFF
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("Request taken while another transaction is in flight.");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_empty) |->
			(rsp.front_value == -32'sd1 && rsp.rear_value == -32'sd1))
		else $error("Empty queue reports stored values.");

	a_load_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (rsp_valid && req_ready))
		else $error("Result load did not show a response and free the request side.");
`endif

endmodule

### hdl/deq_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// Read data is registered and appears in the cycle after the read enable; depends on nothing.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### hdl/deq_ctrl.sv
// Pointer and occupancy control for the double-ended queue.
// Computes the next head, tail and count, the store write and the two read addresses.
// Depends on deq_pkg.
module deq_ctrl
	import deq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [1:0]                 func,
	output logic                       wr_en,
	output logic [$clog2(DEPTH)-1:0]   wr_addr,
	output logic [$clog2(DEPTH)-1:0]   rd_front_addr,
	output logic [$clog2(DEPTH)-1:0]   rd_rear_addr,
	output logic [$clog2(DEPTH+1)-1:0] count_next,
	output deq_flags_t                 flags
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] head_q, tail_q, head_n, tail_n;
	logic [CW-1:0] count_q, count_n;
	logic          empty, full, push;
	logic [1:0]    status;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));

	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		status  = ST_DONE;
		push    = 1'b0;
		wr_addr = tail_q;
		unique case (func)
			OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_PUSH_FULL;
				end else begin
					head_n  = wrap_dec(head_q);
					wr_addr = head_n;
					push    = 1'b1;
					count_n = count_q + CW'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status = ST_PUSH_FULL;
				end else begin
					wr_addr = tail_q;
					tail_n  = wrap_inc(tail_q);
					push    = 1'b1;
					count_n = count_q + CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status = ST_POP_EMPTY;
				end else begin
					head_n  = wrap_inc(head_q);
					count_n = count_q - CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status = ST_POP_EMPTY;
				end else begin
					tail_n  = wrap_dec(tail_q);
					count_n = count_q - CW'(1);
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign wr_en         = accept && push;
	assign rd_front_addr = head_n;
	assign rd_rear_addr  = wrap_dec(tail_n);
	assign count_next    = count_n;

	// A read that hits the entry written in the same cycle takes the pushed value instead.
	assign flags.is_empty  = (count_n == '0);
	assign flags.is_full   = (count_n == CW'(DEPTH));
	assign flags.status    = status;
	assign flags.fwd_front = push && (wr_addr == rd_front_addr);
	assign flags.fwd_rear  = push && (wr_addr == rd_rear_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Occupancy exceeds the store depth.");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("Empty queue with head and tail apart.");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(DEPTH)) |-> (head_q == tail_q))
		else $error("Full queue with head and tail apart.");
`endif

endmodule
